FILE: rtl/core/afrb_pkg.sv
package afrb_pkg;

   localparam int WIDE_W = 52;
   localparam int PROD_W = 50;
   localparam int OPND_W = 33;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [1:0] {
      CSR_RATE_TO_ANGLE = 2'd0,
      CSR_ANGLE_GAIN    = 2'd1,
      CSR_BIAS_GAIN     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] rate_roll;
      logic signed [15:0] rate_pitch;
      logic signed [15:0] rate_yaw;
      logic signed [15:0] meas_roll;
      logic signed [15:0] meas_pitch;
      logic signed [15:0] meas_yaw;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] corr_rate_roll;
      logic signed [15:0] corr_rate_pitch;
      logic signed [15:0] corr_rate_yaw;
      logic signed [15:0] est_roll;
      logic signed [15:0] est_pitch;
      logic signed [15:0] est_yaw;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_CORR,
      OP_MUL_RATE,
      OP_ANG_INT,
      OP_MUL_ERR,
      OP_ANG_PULL,
      OP_DIV_START,
      OP_MUL_BIAS,
      OP_BIAS,
      OP_PUSH
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CORR,
      ST_MUL_RATE,
      ST_ANG_INT,
      ST_MUL_ERR,
      ST_ANG_PULL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_BIAS,
      ST_BIAS,
      ST_PUSH
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_axis;
      logic out_full;
   } status_type;

   function automatic logic signed [31:0] sat32(wide_type v);
      if (v > wide_type'(64'sh7FFF_FFFF)) begin
         return 32'sh7FFF_FFFF;
      end else if (v < -wide_type'(64'sh8000_0000)) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

FILE: rtl/core/afrb_if.sv
interface afrb_req_if import afrb_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface afrb_rsp_if import afrb_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/core/attitude_filter_with_rate_bias.sv
// sequence: each of the three axes takes eight sequencer steps plus a wait on
//   the bit-serial divider; one output push step follows the last axis and
//   stalls while the output register still holds an untaken result
// throughput: one sample at a time; a new sample is
//   taken while the previous result still waits in the output register
// reset: synchronous, active high; clears angle and bias state, sets
//   rate_to_angle to 1 and both gains to 0
module attitude_filter_with_rate_bias import afrb_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   afrb_req_if.sink    req_chan,
   afrb_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   // command and status between sequencer and datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: one axis after another, multiplier and divider shared
   afrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, per-axis state, multiplier, divider,
   // and the output register that decouples the result transfer
   afrb_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );
endmodule

FILE: rtl/core/afrb_div.sv
module afrb_div import afrb_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [OPND_W-1:0] dividend,
   input  logic [15:0]              divisor,
   output logic                     done,
   output logic signed [OPND_W-1:0] quotient
);
   logic [15:0]       rem_ff, rem_in;
   logic [OPND_W-1:0] mag_ff, mag_in;
   logic [15:0]       dvs_ff;
   logic              neg_ff;
   logic [5:0]        cnt_ff;
   logic              busy_ff, done_ff;
   logic [16:0]       shifted;
   logic [16:0]       diff;

   // one quotient bit per cycle, restoring
   always_comb begin
      shifted = {rem_ff, mag_ff[OPND_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (shifted >= {1'b0, dvs_ff}) begin
         rem_in = diff[15:0];
         mag_in = {mag_ff[OPND_W-2:0], 1'b1};
      end else begin
         rem_in = shifted[15:0];
         mag_in = {mag_ff[OPND_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(OPND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         mag_ff <= dividend[OPND_W-1] ? OPND_W'(-dividend) : OPND_W'(dividend);
         neg_ff <= dividend[OPND_W-1];
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         mag_ff <= mag_in;
      end
   end

   assign done     = done_ff;
   assign quotient = (dvs_ff == 16'd0) ? '0 :
                     (neg_ff ? -signed'(mag_ff) : signed'(mag_ff));
endmodule

FILE: rtl/core/afrb_ctrl.sv
module afrb_ctrl import afrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CORR;
            end
         end
         ST_CORR: begin
            cmd.op   = OP_CORR;
            state_in = ST_MUL_RATE;
         end
         ST_MUL_RATE: begin
            cmd.op   = OP_MUL_RATE;
            state_in = ST_ANG_INT;
         end
         ST_ANG_INT: begin
            cmd.op   = OP_ANG_INT;
            state_in = ST_MUL_ERR;
         end
         ST_MUL_ERR: begin
            cmd.op   = OP_MUL_ERR;
            state_in = ST_ANG_PULL;
         end
         ST_ANG_PULL: begin
            cmd.op   = OP_ANG_PULL;
            state_in = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               state_in = ST_MUL_BIAS;
            end
         end
         ST_MUL_BIAS: begin
            cmd.op   = OP_MUL_BIAS;
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            cmd.op   = OP_BIAS;
            state_in = status.last_axis ? ST_PUSH : ST_CORR;
         end
         ST_PUSH: begin
            if (!status.out_full) begin
               cmd.op   = OP_PUSH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

FILE: rtl/core/afrb_dp.sv
module afrb_dp import afrb_pkg::*; #(
   parameter int FRAC_BITS = 14
) (
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         cmd,
   output status_type      status,
   input  req_payload_type req_payload,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);
   logic [15:0]        r2a_ff, again_ff, bgain_ff;
   req_payload_type    in_ff;
   logic [1:0]         axis_ff;
   logic signed [31:0] est_ff [3];
   logic signed [31:0] bias_ff [3];
   logic signed [31:0] meas_ff, corr_ff, ang_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [15:0] corr_out_ff [3];
   logic signed [15:0] est_out_ff [3];
   rsp_payload_type    rsp_payload_ff;
   logic               rsp_valid_ff;

   logic signed [15:0]       raw_rate, raw_meas;
   logic signed [31:0]       cur_est, cur_bias;
   logic signed [OPND_W-1:0] mul_a, err;
   logic signed [16:0]       mul_b;
   logic signed [OPND_W-1:0] quot;
   logic                     div_done;
   wide_type                 prod_q;

   function automatic logic signed [31:0] widen(logic signed [15:0] x);
      return sat32(wide_type'(x) <<< FRAC_BITS);
   endfunction

   function automatic logic signed [15:0] narrow16(logic signed [31:0] v);
      logic signed [31:0] n;
      n = v >>> FRAC_BITS;
      if (n > 32'sd32767) begin
         return 16'sh7FFF;
      end else if (n < -32'sd32768) begin
         return 16'sh8000;
      end
      return n[15:0];
   endfunction

   always_comb begin
      case (axis_ff)
         2'd0:    begin raw_rate = in_ff.rate_roll;  raw_meas = in_ff.meas_roll;  end
         2'd1:    begin raw_rate = in_ff.rate_pitch; raw_meas = in_ff.meas_pitch; end
         default: begin raw_rate = in_ff.rate_yaw;   raw_meas = in_ff.meas_yaw;   end
      endcase
      cur_est  = est_ff[axis_ff];
      cur_bias = bias_ff[axis_ff];
      err      = OPND_W'(ang_ff) - OPND_W'(meas_ff);
      prod_q   = wide_type'(prod_ff >>> FRAC_BITS);
   end

   // shared multiplier operand select
   always_comb begin
      case (cmd.op)
         OP_MUL_ERR:  begin mul_a = err;  mul_b = signed'({1'b0, again_ff}); end
         OP_MUL_BIAS: begin mul_a = quot; mul_b = signed'({1'b0, bgain_ff}); end
         default:     begin mul_a = OPND_W'(corr_ff); mul_b = signed'({1'b0, r2a_ff}); end
      endcase
   end

   afrb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV_START),
      .dividend (err),
      .divisor  (r2a_ff),
      .done     (div_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         r2a_ff   <= 16'd1;
         again_ff <= '0;
         bgain_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RATE_TO_ANGLE: r2a_ff   <= csr_wdata;
            CSR_ANGLE_GAIN:    again_ff <= csr_wdata;
            CSR_BIAS_GAIN:     bgain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            est_ff[i]  <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         if (cmd.op == OP_PUSH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            OP_LOAD: axis_ff <= '0;
            OP_BIAS: begin
               bias_ff[axis_ff] <= sat32(wide_type'(cur_bias) + prod_q);
               est_ff[axis_ff]  <= ang_ff;
               axis_ff          <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: in_ff <= req_payload;
         OP_CORR: begin
            meas_ff <= widen(raw_meas);
            corr_ff <= sat32(wide_type'(widen(raw_rate)) - wide_type'(cur_bias));
         end
         OP_MUL_RATE, OP_MUL_ERR, OP_MUL_BIAS: prod_ff <= PROD_W'(mul_a * mul_b);
         OP_ANG_INT:  ang_ff <= sat32(wide_type'(cur_est) + prod_q);
         OP_ANG_PULL: ang_ff <= sat32(wide_type'(ang_ff) - prod_q);
         OP_BIAS: begin
            corr_out_ff[axis_ff] <= narrow16(corr_ff);
            est_out_ff[axis_ff]  <= narrow16(ang_ff);
         end
         OP_PUSH: begin
            rsp_payload_ff.corr_rate_roll  <= corr_out_ff[0];
            rsp_payload_ff.corr_rate_pitch <= corr_out_ff[1];
            rsp_payload_ff.corr_rate_yaw   <= corr_out_ff[2];
            rsp_payload_ff.est_roll        <= est_out_ff[0];
            rsp_payload_ff.est_pitch       <= est_out_ff[1];
            rsp_payload_ff.est_yaw         <= est_out_ff[2];
         end
         default: ;
      endcase
   end

   assign status.div_done  = div_done;
   assign status.last_axis = (axis_ff == 2'd2);
   assign status.out_full  = rsp_valid_ff && !rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_payload      = rsp_payload_ff;
endmodule

FILE: rtl/core/afrb_checker.sv
module afrb_checker import afrb_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_payload
);
   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // one sample at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample taken while busy");

   // a result never appears the cycle after a sample transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result too early");
endmodule

bind attitude_filter_with_rate_bias afrb_checker u_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
